/* rtl/core/lp2c_pkg.sv */
// Shared constants and the arctangent table for the LiDAR polar-to-Cartesian converter.
// Used by lidar_polar_to_cartesian; depends on nothing else.
`timescale 1ns / 1ps

package lp2c_pkg;

  // Default structural parameters.
  localparam int DEF_INDEX_BITS    = 12;
  localparam int DEF_RANGE_BITS    = 20;
  localparam int DEF_ANGLE_BITS    = 32;
  localparam int DEF_CORDIC_STAGES = 18;

  // Configuration port geometry and register indices.
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 32;
  localparam logic [CFG_INDEX_BITS-1:0] REG_START_ANGLE = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ANGLE_STEP  = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MIN_RANGE   = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_RANGE   = 3'd3;

  // Angle register width and the fixed residual angle width (2^-32 turns).
  localparam int ANG_REG_BITS = 32;
  localparam int Z_BITS       = 32;

  // CORDIC gain compensation, 0.60725293 in Q0.32, and guard bits kept below the range unit.
  localparam logic [31:0] GAIN_Q32   = 32'd2608131496;
  localparam int          GUARD_BITS = 16;

  // atan(2^-i) in 2^-32 turns.
  function automatic logic signed [Z_BITS-1:0] cordic_atan(input int i);
    logic signed [Z_BITS-1:0] v;
    unique case (i)
      0:  v = 32'sd536870912;
      1:  v = 32'sd316933406;
      2:  v = 32'sd167458907;
      3:  v = 32'sd85004756;
      4:  v = 32'sd42667331;
      5:  v = 32'sd21354465;
      6:  v = 32'sd10680862;
      7:  v = 32'sd5340245;
      8:  v = 32'sd2670163;
      9:  v = 32'sd1335087;
      10: v = 32'sd667544;
      11: v = 32'sd333772;
      12: v = 32'sd166886;
      13: v = 32'sd83443;
      14: v = 32'sd41722;
      15: v = 32'sd20861;
      16: v = 32'sd10430;
      17: v = 32'sd5215;
      18: v = 32'sd2608;
      19: v = 32'sd1304;
      20: v = 32'sd652;
      21: v = 32'sd326;
      22: v = 32'sd163;
      23: v = 32'sd81;
      24: v = 32'sd41;
      25: v = 32'sd20;
      26: v = 32'sd10;
      27: v = 32'sd5;
      28: v = 32'sd3;
      29: v = 32'sd1;
      30: v = 32'sd1;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

endpackage

/* rtl/core/lidar_polar_to_cartesian.sv */
// Pipeline: stage A, the CORDIC stages and the output register lie between input transfer and result.
// Throughput: one sample per cycle; each pipeline stage loads when it is empty or its
// content moves on, so a stalled output only holds the stages behind it that are full.
// Reset (synchronous, rst_n low) empties the pipeline and loads the registers with
// start_angle = 0, angle_step = 0, min_range = 0, max_range = all ones.
// Depends on lp2c_pkg.
`timescale 1ns / 1ps

module lidar_polar_to_cartesian #(
  parameter int INDEX_BITS    = lp2c_pkg::DEF_INDEX_BITS,
  parameter int RANGE_BITS    = lp2c_pkg::DEF_RANGE_BITS,
  parameter int ANGLE_BITS    = lp2c_pkg::DEF_ANGLE_BITS,
  parameter int CORDIC_STAGES = lp2c_pkg::DEF_CORDIC_STAGES
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  // Configuration writes
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [lp2c_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [lp2c_pkg::CFG_DATA_BITS-1:0]      cfg_data,
  // Sample input
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic [INDEX_BITS-1:0]                   in_sample_index,
  input  logic [RANGE_BITS-1:0]                   in_range_value,
  input  logic                                    in_range_finite,
  input  logic                                    in_scan_end,
  // Point output
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [RANGE_BITS:0]              out_point_x,
  output logic signed [RANGE_BITS:0]              out_point_y,
  output logic                                    out_point_valid,
  output logic                                    out_scan_last
);

  localparam int N    = CORDIC_STAGES;
  localparam int GB   = lp2c_pkg::GUARD_BITS;
  localparam int ZW   = lp2c_pkg::Z_BITS;
  localparam int VW   = RANGE_BITS + GB;        // scaled range width
  localparam int PW   = RANGE_BITS + 32;        // range times gain product width
  localparam int XW   = RANGE_BITS + GB + 3;    // CORDIC vector width with growth headroom
  localparam int RW   = XW - GB;                // rounded width before saturation

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [lp2c_pkg::ANG_REG_BITS-1:0] start_angle_r;
  logic [lp2c_pkg::ANG_REG_BITS-1:0] angle_step_r;
  logic [RANGE_BITS-1:0]             min_range_r;
  logic [RANGE_BITS-1:0]             max_range_r;

  assign cfg_ready = 1'b1;

  // A write to an index beyond the register list is dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_angle_r <= '0;
      angle_step_r  <= '0;
      min_range_r   <= '0;
      max_range_r   <= '1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lp2c_pkg::REG_START_ANGLE: start_angle_r <= cfg_data;
        lp2c_pkg::REG_ANGLE_STEP:  angle_step_r  <= cfg_data;
        lp2c_pkg::REG_MIN_RANGE:   min_range_r   <= cfg_data[RANGE_BITS-1:0];
        lp2c_pkg::REG_MAX_RANGE:   max_range_r   <= cfg_data[RANGE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline registers
  // ---------------------------------------------------------------------------
  // Stage A: angle product, scaled range, window check.
  logic                     a_vld_r, a_ok_r, a_last_r;
  logic [ANGLE_BITS-1:0]    a_prod_r;
  logic [VW-1:0]            a_gain_r;

  // CORDIC stages: index 0 holds the start vector, index i+1 the result of iteration i.
  logic                     c_vld_r  [0:N];
  logic                     c_ok_r   [0:N];
  logic                     c_last_r [0:N];
  logic signed [XW-1:0]     c_x_r    [0:N];
  logic signed [XW-1:0]     c_y_r    [0:N];
  logic signed [ZW-1:0]     c_z_r    [0:N];

  // Start vector and the results of the rotation iterations.
  logic signed [XW-1:0]     c0_x_nxt, c0_y_nxt;
  logic signed [ZW-1:0]     c0_z_nxt;
  logic signed [XW-1:0]     c_x_nxt  [1:N];
  logic signed [XW-1:0]     c_y_nxt  [1:N];
  logic signed [ZW-1:0]     c_z_nxt  [1:N];

  // Output register.
  logic                     out_valid_r, out_ok_r, out_last_r;
  logic signed [RANGE_BITS:0] out_x_r, out_y_r;
  logic signed [RANGE_BITS:0] out_x_nxt, out_y_nxt;

  // ---------------------------------------------------------------------------
  // Load enables: a stage loads when it is empty or its content moves on
  // ---------------------------------------------------------------------------
  logic ld_out, ld_a;
  logic ld_c [0:N];

  always_comb begin
    ld_out = !out_valid_r || out_ready;
    ld_c[N] = !c_vld_r[N] || ld_out;
    for (int k = N - 1; k >= 0; k--) begin
      ld_c[k] = !c_vld_r[k] || ld_c[k+1];
    end
    ld_a = !a_vld_r || ld_c[0];
  end

  assign in_ready = ld_a;

  // ---------------------------------------------------------------------------
  // Stage A logic: index times step (modulo a full turn) and range times gain
  // ---------------------------------------------------------------------------
  logic [ANGLE_BITS-1:0] a_prod_nxt;
  logic [PW-1:0]         gain_prod;
  logic                  a_ok_nxt;

  always_comb begin
    a_prod_nxt = ANGLE_BITS'(ANGLE_BITS'(in_sample_index) * angle_step_r[ANGLE_BITS-1:0]);
    gain_prod  = PW'(in_range_value) * PW'(lp2c_pkg::GAIN_Q32);
    a_ok_nxt   = in_range_finite && (in_range_value < max_range_r) &&
                 (in_range_value > min_range_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (ld_a) begin
      a_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_a) begin
      a_ok_r   <= a_ok_nxt;
      a_last_r <= in_scan_end;
      a_prod_r <= a_prod_nxt;
      a_gain_r <= gain_prod[PW-1:32-GB];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage B logic: beam angle, quadrant pre-rotation and residual angle
  // ---------------------------------------------------------------------------
  logic [ANGLE_BITS-1:0] angle;
  logic [1:0]            quad;
  logic signed [XW-1:0]  v_pos;

  always_comb begin
    angle = ANGLE_BITS'(start_angle_r[ANGLE_BITS-1:0] + a_prod_r);
    quad  = angle[ANGLE_BITS-1:ANGLE_BITS-2];
    v_pos = signed'(XW'(a_gain_r));
    c0_z_nxt = signed'(ZW'(angle[ANGLE_BITS-3:0]) << (ZW - ANGLE_BITS));
    unique case (quad)
      2'd0: begin c0_x_nxt = v_pos;  c0_y_nxt = '0;     end
      2'd1: begin c0_x_nxt = '0;     c0_y_nxt = v_pos;  end
      2'd2: begin c0_x_nxt = -v_pos; c0_y_nxt = '0;     end
      default: begin c0_x_nxt = '0;  c0_y_nxt = -v_pos; end
    endcase
  end

  // ---------------------------------------------------------------------------
  // CORDIC rotation iterations, one per stage
  // ---------------------------------------------------------------------------
  always_comb begin
    for (int i = 0; i < N; i++) begin
      if (!c_z_r[i][ZW-1]) begin
        c_x_nxt[i+1] = c_x_r[i] - (c_y_r[i] >>> i);
        c_y_nxt[i+1] = c_y_r[i] + (c_x_r[i] >>> i);
        c_z_nxt[i+1] = c_z_r[i] - lp2c_pkg::cordic_atan(i);
      end else begin
        c_x_nxt[i+1] = c_x_r[i] + (c_y_r[i] >>> i);
        c_y_nxt[i+1] = c_y_r[i] - (c_x_r[i] >>> i);
        c_z_nxt[i+1] = c_z_r[i] + lp2c_pkg::cordic_atan(i);
      end
    end
  end

  // Valid bits of the CORDIC stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= N; k++) begin
        c_vld_r[k] <= 1'b0;
      end
    end else begin
      if (ld_c[0]) begin
        c_vld_r[0] <= a_vld_r;
      end
      for (int k = 1; k <= N; k++) begin
        if (ld_c[k]) begin
          c_vld_r[k] <= c_vld_r[k-1];
        end
      end
    end
  end

  // Payload of the CORDIC stages.
  always_ff @(posedge clk) begin
    if (ld_c[0]) begin
      c_ok_r[0]   <= a_ok_r;
      c_last_r[0] <= a_last_r;
      c_x_r[0]    <= c0_x_nxt;
      c_y_r[0]    <= c0_y_nxt;
      c_z_r[0]    <= c0_z_nxt;
    end
    for (int k = 1; k <= N; k++) begin
      if (ld_c[k]) begin
        c_ok_r[k]   <= c_ok_r[k-1];
        c_last_r[k] <= c_last_r[k-1];
        c_x_r[k]    <= c_x_nxt[k];
        c_y_r[k]    <= c_y_nxt[k];
        c_z_r[k]    <= c_z_nxt[k];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output stage: round half up, saturate, zero the coordinates of rejected samples
  // ---------------------------------------------------------------------------
  logic signed [XW-1:0] x_bias, y_bias;
  logic signed [RW-1:0] x_rnd, y_rnd;

  function automatic logic signed [RANGE_BITS:0] sat_out(input logic signed [RW-1:0] v);
    logic fits;
    fits = (v[RW-1:RANGE_BITS] == '0) || (v[RW-1:RANGE_BITS] == '1);
    if (fits) begin
      return v[RANGE_BITS:0];
    end else if (v[RW-1]) begin
      return {1'b1, {RANGE_BITS{1'b0}}};
    end else begin
      return {1'b0, {RANGE_BITS{1'b1}}};
    end
  endfunction

  always_comb begin
    x_bias = c_x_r[N] + (XW'(1) <<< (GB - 1));
    y_bias = c_y_r[N] + (XW'(1) <<< (GB - 1));
    x_rnd  = RW'(x_bias >>> GB);
    y_rnd  = RW'(y_bias >>> GB);
    if (c_ok_r[N]) begin
      out_x_nxt = sat_out(x_rnd);
      out_y_nxt = sat_out(y_rnd);
    end else begin
      out_x_nxt = '0;
      out_y_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ld_out) begin
      out_valid_r <= c_vld_r[N];
    end
  end

  always_ff @(posedge clk) begin
    if (ld_out) begin
      out_ok_r   <= c_ok_r[N];
      out_last_r <= c_last_r[N];
      out_x_r    <= out_x_nxt;
      out_y_r    <= out_y_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_point_x     = out_x_r;
  assign out_point_y     = out_y_r;
  assign out_point_valid = out_ok_r;
  assign out_scan_last   = out_last_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // A rejected sample never carries coordinates.
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_point_valid) |-> (out_point_x == '0 && out_point_y == '0))
    else $error("rejected sample has non-zero coordinates");

  // Input is only held off while the first stage holds an item.
  a_block_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> a_vld_r)
    else $error("input stalled with an empty first stage");

  // An item leaving the last CORDIC stage appears at the output.
  a_last_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (c_vld_r[N] && ld_out) |=> out_valid)
    else $error("item lost between CORDIC and output register");

  // A stalled pipeline keeps the item in the last CORDIC stage.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (c_vld_r[N] && !ld_out) |=> (c_vld_r[N] && $stable(c_x_r[N]) && $stable(c_y_r[N])))
    else $error("last CORDIC stage changed during a stall");

endmodule
